/* src/mlrq_pkg.sv */
// shared types, constants and helpers for the multilevel ready queue
package mlrq_pkg;

   // sizing
   localparam int NUM_LEVELS = 6;
   localparam int NUM_SLOTS  = 64;
   localparam int LVL_W      = $clog2(NUM_LEVELS);
   localparam int ADDR_W     = $clog2(NUM_SLOTS);

   // field widths fixed by the transaction format
   localparam int CMD_W     = 2;
   localparam int SLOT_W    = 6;
   localparam int PRIO_W    = 3;
   localparam int STATUS_W  = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   // status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NONE_READY = 2'd1,
      STATUS_NOT_QUEUED = 2'd2,
      STATUS_ALREADY    = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_EXEC
   } seq_state_type;

   // update request to the per-level head/tail table
   typedef struct packed {
      logic              wr_head;
      logic              wr_tail;
      logic              set_nonempty;
      logic              clr_nonempty;
      logic [LVL_W-1:0]  level;
      logic [SLOT_W-1:0] head;
      logic [SLOT_W-1:0] tail;
   } level_upd_type;

   // view of the per-level table
   typedef struct packed {
      logic              any;
      logic [LVL_W-1:0]  top;
      logic [SLOT_W-1:0] head;
      logic [SLOT_W-1:0] tail;
      logic              nonempty;
   } level_view_type;

   // priority clamped to the highest level
   function automatic logic [LVL_W-1:0] clamp_level(input logic [PRIO_W-1:0] prio);
      logic [LVL_W-1:0] lv;
      if (32'(prio) >= NUM_LEVELS) begin
         lv = LVL_W'(NUM_LEVELS - 1);
      end else begin
         lv = LVL_W'(prio);
      end
      return lv;
   endfunction

endpackage

/* src/mlrq_link_ram.sv */
// generic single-write, single-read memory with registered read data
module mlrq_link_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mlrq_level_table.sv */
// per-level head, tail and nonempty registers with highest-level search
module mlrq_level_table import mlrq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic [LVL_W-1:0] query_level,
   input  level_upd_type  upd,
   output level_view_type view
);

   logic [SLOT_W-1:0]     head_ff [NUM_LEVELS];
   logic [SLOT_W-1:0]     tail_ff [NUM_LEVELS];
   logic [NUM_LEVELS-1:0] nonempty_ff;
   logic [NUM_LEVELS-1:0] nonempty_in;
   logic [LVL_W-1:0]      top;

   // highest nonempty level, later levels win
   always_comb begin
      top = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (nonempty_ff[i]) begin
            top = LVL_W'(i);
         end
      end
   end

   // view for the sequencer
   always_comb begin
      view.any      = |nonempty_ff;
      view.top      = top;
      view.head     = head_ff[query_level];
      view.tail     = tail_ff[query_level];
      view.nonempty = nonempty_ff[query_level];
   end

   // nonempty marks
   always_comb begin
      nonempty_in = nonempty_ff;
      if (upd.set_nonempty) begin
         nonempty_in[upd.level] = 1'b1;
      end
      if (upd.clr_nonempty) begin
         nonempty_in[upd.level] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= '0;
      end else begin
         nonempty_ff <= nonempty_in;
      end
   end

   // head and tail pointers
   always_ff @(posedge clock) begin
      if (upd.wr_head) begin
         head_ff[upd.level] <= upd.head;
      end
      if (upd.wr_tail) begin
         tail_ff[upd.level] <= upd.tail;
      end
   end

endmodule

/* src/multilevel_ready_queue.sv */
// top level of the multilevel priority ready queue
// A ready queue of task slots with one FIFO per priority level; the highest
// level is the most urgent. Each request transaction (push, pop or remove)
// gives exactly one response transaction. The request is taken in SEQ_IDLE,
// the next, previous and level link memories are read in SEQ_READ, and the
// operation is applied and its response registered in SEQ_EXEC. The response
// register lets the next request be taken while a response still waits; if
// the response is still held when the following operation finishes, that
// operation waits in its last step. No clearing pass is needed after reset.
module multilevel_ready_queue import mlrq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // command[1:0], task_slot[7:2], task_priority[10:8], zero [15:11]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // result_slot[5:0], status[7:6]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   seq_state_type state_ff, state_in;

   cmd_type           cmd_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [PRIO_W-1:0] prio_ff;

   logic [NUM_SLOTS-1:0] queued_ff, queued_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   status_type            rsp_status_ff, rsp_status_in;

   level_upd_type  lvl_upd;
   level_view_type lvl_view;
   logic [LVL_W-1:0] query_level;

   logic [ADDR_W-1:0] rd_addr;
   logic [SLOT_W-1:0] rd_next, rd_prev;
   logic [LVL_W-1:0]  rd_level;

   logic              next_we, prev_we, level_we;
   logic [ADDR_W-1:0] next_waddr, prev_waddr, level_waddr;
   logic [SLOT_W-1:0] next_wdata, prev_wdata;
   logic [LVL_W-1:0]  level_wdata;

   logic             accept, done, slot_ok;
   logic [ADDR_W-1:0] slot_idx, head_idx;
   logic [LVL_W-1:0]  push_level;
   logic             is_head, is_tail;

   assign accept     = req_tvalid && req_tready;
   assign slot_ok    = 32'(slot_ff) < NUM_SLOTS;
   assign slot_idx   = ADDR_W'(slot_ff);
   assign head_idx   = ADDR_W'(lvl_view.head);
   assign push_level = clamp_level(prio_ff);
   assign done       = (state_ff == SEQ_EXEC) && (!rsp_valid_ff || rsp_tready);

   // level looked at by the current operation
   always_comb begin
      case (cmd_ff)
         CMD_PUSH:   query_level = push_level;
         CMD_POP:    query_level = lvl_view.top;
         CMD_REMOVE: query_level = rd_level;
         default:    query_level = push_level;
      endcase
   end

   // link read address: the popped head or the named slot
   assign rd_addr = (cmd_ff == CMD_POP) ? head_idx : slot_idx;

   assign is_head = (lvl_view.head == slot_ff);
   assign is_tail = (lvl_view.tail == slot_ff);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = SEQ_READ;
            end
         end
         SEQ_READ: state_in = SEQ_EXEC;
         SEQ_EXEC: begin
            if (done) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= cmd_type'(req_tdata[1:0]);
         slot_ff <= req_tdata[7:2];
         prio_ff <= req_tdata[10:8];
      end
   end

   // operation: link writes, level updates, queued marks and response
   always_comb begin
      lvl_upd       = '0;
      lvl_upd.level = query_level;
      next_we       = 1'b0;
      prev_we       = 1'b0;
      level_we      = 1'b0;
      next_waddr    = slot_idx;
      next_wdata    = slot_ff;
      prev_waddr    = slot_idx;
      prev_wdata    = lvl_view.tail;
      level_waddr   = slot_idx;
      level_wdata   = push_level;
      queued_in     = queued_ff;
      rsp_slot_in   = '0;
      rsp_status_in = STATUS_OK;
      case (cmd_ff)
         CMD_PUSH: begin
            if (!slot_ok) begin
               rsp_status_in = STATUS_NOT_QUEUED;
            end else if (queued_ff[slot_idx]) begin
               rsp_status_in = STATUS_ALREADY;
            end else begin
               rsp_slot_in         = slot_ff;
               level_we            = done;
               queued_in[slot_idx] = 1'b1;
               lvl_upd.wr_tail     = done;
               lvl_upd.tail        = slot_ff;
               if (!lvl_view.nonempty) begin
                  lvl_upd.wr_head      = done;
                  lvl_upd.head         = slot_ff;
                  lvl_upd.set_nonempty = done;
               end else begin
                  // append after the current tail
                  next_we    = done;
                  next_waddr = ADDR_W'(lvl_view.tail);
                  prev_we    = done;
               end
            end
         end
         CMD_POP: begin
            if (!lvl_view.any) begin
               rsp_status_in = STATUS_NONE_READY;
            end else begin
               rsp_slot_in         = lvl_view.head;
               queued_in[head_idx] = 1'b0;
               if (lvl_view.tail == lvl_view.head) begin
                  lvl_upd.clr_nonempty = done;
               end else begin
                  lvl_upd.wr_head = done;
                  lvl_upd.head    = rd_next;
               end
            end
         end
         CMD_REMOVE: begin
            if (!slot_ok || !queued_ff[slot_idx]) begin
               rsp_status_in = STATUS_NOT_QUEUED;
            end else begin
               rsp_slot_in         = slot_ff;
               queued_in[slot_idx] = 1'b0;
               if (is_head && is_tail) begin
                  lvl_upd.clr_nonempty = done;
               end else if (is_head) begin
                  lvl_upd.wr_head = done;
                  lvl_upd.head    = rd_next;
               end else if (is_tail) begin
                  lvl_upd.wr_tail = done;
                  lvl_upd.tail    = rd_prev;
               end else begin
                  // splice neighbors around the slot
                  next_we    = done;
                  next_waddr = ADDR_W'(rd_prev);
                  next_wdata = rd_next;
                  prev_we    = done;
                  prev_waddr = ADDR_W'(rd_next);
                  prev_wdata = rd_prev;
               end
            end
         end
         default: begin
            rsp_status_in = STATUS_OK;
         end
      endcase
      if (!done) begin
         queued_in = queued_ff;
      end
   end

   // queued marks
   always_ff @(posedge clock) begin
      if (reset) begin
         queued_ff <= '0;
      end else begin
         queued_ff <= queued_in;
      end
   end

   // response register
   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_slot_ff   <= rsp_slot_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_status_ff, rsp_slot_ff};

   // per-level head and tail table
   mlrq_level_table u_level_table (
      .clock       (clock),
      .reset       (reset),
      .query_level (query_level),
      .upd         (lvl_upd),
      .view        (lvl_view)
   );

   // link memories indexed by slot
   mlrq_link_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_next)
   );

   mlrq_link_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_prev)
   );

   mlrq_link_ram #(.WIDTH(LVL_W), .DEPTH(NUM_SLOTS)) u_level_ram (
      .clock   (clock),
      .wr_en   (level_we),
      .wr_addr (level_waddr),
      .wr_data (level_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_level)
   );

endmodule

/* bench/ready_queue_checker.sv */
// transaction checker with its own ready queue predictor
`timescale 1ns / 100ps

module ready_queue_checker import mlrq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // command[1:0], task_slot[7:2], task_priority[10:8], zero [15:11]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // result_slot[5:0], status[7:6]
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    fail_count,
   output int                    pending_count
);

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      status_type        status;
   } queue_result_type;

   // predicted queue contents
   logic [SLOT_W-1:0] lvl_head     [NUM_LEVELS];
   logic [SLOT_W-1:0] lvl_tail     [NUM_LEVELS];
   logic              lvl_nonempty [NUM_LEVELS];
   logic [SLOT_W-1:0] link_next    [NUM_SLOTS];
   logic [SLOT_W-1:0] link_prev    [NUM_SLOTS];
   logic              in_queue     [NUM_SLOTS];
   logic [LVL_W-1:0]  owner_level  [NUM_SLOTS];

   // responses still owed by the block, oldest first
   queue_result_type expected_rsp[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // detach a queued slot from the list of its level
   task automatic detach_slot(input logic [SLOT_W-1:0] s);
      logic [LVL_W-1:0] lv;
      logic             at_head;
      logic             at_tail;
      lv      = owner_level[s];
      at_head = (lvl_head[lv] == s);
      at_tail = (lvl_tail[lv] == s);
      if (at_head && at_tail) begin
         lvl_nonempty[lv] = 1'b0;
      end else if (at_head) begin
         lvl_head[lv] = link_next[s];
      end else if (at_tail) begin
         lvl_tail[lv] = link_prev[s];
      end else begin
         link_next[link_prev[s]] = link_next[s];
         link_prev[link_next[s]] = link_prev[s];
      end
      in_queue[s] = 1'b0;
   endtask

   // apply one operation to the predicted queue and give its response
   task automatic predict_queue_op(input cmd_type op, input logic [SLOT_W-1:0] slot,
                                   input logic [PRIO_W-1:0] prio,
                                   output queue_result_type res);
      logic [LVL_W-1:0]  lv;
      logic [SLOT_W-1:0] taken;
      logic              found;
      res.slot   = '0;
      res.status = STATUS_OK;
      found      = 1'b0;
      case (op)
         CMD_PUSH: begin
            if (in_queue[slot]) begin
               res.status = STATUS_ALREADY;
            end else begin
               // priorities above the top level land on the top level
               if (int'(prio) >= NUM_LEVELS) lv = LVL_W'(NUM_LEVELS - 1);
               else lv = LVL_W'(prio);
               owner_level[slot] = lv;
               in_queue[slot]    = 1'b1;
               if (!lvl_nonempty[lv]) begin
                  lvl_head[lv]     = slot;
                  lvl_tail[lv]     = slot;
                  lvl_nonempty[lv] = 1'b1;
               end else begin
                  link_next[lvl_tail[lv]] = slot;
                  link_prev[slot]         = lvl_tail[lv];
                  lvl_tail[lv]            = slot;
               end
               res.slot = slot;
            end
         end
         CMD_POP: begin
            for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
               if (!found && lvl_nonempty[l]) begin
                  found = 1'b1;
                  taken = lvl_head[l];
                  detach_slot(taken);
                  res.slot = taken;
               end
            end
            if (!found) res.status = STATUS_NONE_READY;
         end
         CMD_REMOVE: begin
            if (!in_queue[slot]) begin
               res.status = STATUS_NOT_QUEUED;
            end else begin
               detach_slot(slot);
               res.slot = slot;
            end
         end
         default: begin
         end
      endcase
   endtask

   // responses are checked before the request of the same edge is predicted
   always @(posedge clock) begin
      queue_result_type want;
      queue_result_type got;
      if (reset) begin
         for (int l = 0; l < NUM_LEVELS; l++) lvl_nonempty[l] = 1'b0;
         for (int s = 0; s < NUM_SLOTS; s++) in_queue[s] = 1'b0;
         expected_rsp.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.slot   = rsp_tdata[SLOT_W-1:0];
            got.status = status_type'(rsp_tdata[SLOT_W +: STATUS_W]);
            if (expected_rsp.size() == 0) begin
               fail_count++;
               $display("%0t: response with none expected, actual slot %0d status %0d",
                        $time, got.slot, got.status);
            end else begin
               want = expected_rsp.pop_front();
               if (got.slot !== want.slot) begin
                  fail_count++;
                  $display("%0t: result_slot expected %0d actual %0d",
                           $time, want.slot, got.slot);
               end
               if (got.status !== want.status) begin
                  fail_count++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_queue_op(cmd_type'(req_tdata[CMD_W-1:0]),
                             req_tdata[CMD_W +: SLOT_W],
                             req_tdata[CMD_W + SLOT_W +: PRIO_W], want);
            expected_rsp.push_back(want);
         end
      end
      pending_count = expected_rsp.size();
   end

endmodule

/* bench/multilevel_ready_queue_test.sv */
// stimulus and verdict for the multilevel ready queue
`timescale 1ns / 100ps

module multilevel_ready_queue_test;
   import mlrq_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int CHUNK_ITEMS   = 50;
   localparam int RANDOM_CHUNKS = 18;
   localparam int QUIET_CHUNKS  = 2;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_BALANCED
   } traffic_mix_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int fail_count;
   int pending_count;
   int cycle_count;
   bit sender_idle;
   bit receiver_stall;

   multilevel_ready_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ready_queue_checker queue_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("multilevel_ready_queue_test: FAIL");
      $finish;
   end

   // response side: random stall bursts while enabled
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (receiver_stall && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_tready = 1'b1;
         end
      end
   end

   // one request transaction, entered and left at a falling edge
   task automatic send_req(input cmd_type op, input logic [SLOT_W-1:0] slot,
                           input logic [PRIO_W-1:0] prio);
      int gap;
      gap = 0;
      if (sender_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {5'b0, prio, slot, op};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // hold off until every response has come back
   task automatic drain_responses;
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // one random operation shaped by the traffic mix
   task automatic random_req(input traffic_mix_type mix, input bit narrow);
      int pick;
      int push_pct;
      int pop_pct;
      int remove_pct;
      logic [SLOT_W-1:0] slot;
      logic [PRIO_W-1:0] prio;
      case (mix)
         MIX_FILL:  begin push_pct = 65; pop_pct = 10; remove_pct = 20; end
         MIX_DRAIN: begin push_pct = 20; pop_pct = 55; remove_pct = 20; end
         default:   begin push_pct = 40; pop_pct = 30; remove_pct = 25; end
      endcase
      pick = $urandom_range(0, 99);
      slot = narrow ? SLOT_W'($urandom_range(0, 7)) : SLOT_W'($urandom_range(0, 63));
      prio = PRIO_W'($urandom_range(0, 7));
      if (pick < push_pct) send_req(CMD_PUSH, slot, prio);
      else if (pick < push_pct + pop_pct) send_req(CMD_POP, slot, prio);
      else if (pick < push_pct + pop_pct + remove_pct) send_req(CMD_REMOVE, slot, prio);
      else send_req(CMD_NOP, slot, prio);
   endtask

   // main sequence
   initial begin
      traffic_mix_type mix;
      bit              narrow;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      sender_idle    = 1'b1;
      receiver_stall = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty queue, clamping, duplicates, unlink positions
      send_req(CMD_POP,    6'd0,  3'd0);
      send_req(CMD_REMOVE, 6'd5,  3'd0);
      send_req(CMD_PUSH,   6'd0,  3'd0);
      send_req(CMD_PUSH,   6'd63, 3'd7);
      send_req(CMD_PUSH,   6'd21, 3'd5);
      send_req(CMD_PUSH,   6'd42, 3'd6);
      send_req(CMD_PUSH,   6'd0,  3'd3);
      send_req(CMD_PUSH,   6'd10, 3'd2);
      send_req(CMD_PUSH,   6'd11, 3'd2);
      send_req(CMD_PUSH,   6'd12, 3'd2);
      send_req(CMD_REMOVE, 6'd12, 3'd0);
      send_req(CMD_REMOVE, 6'd10, 3'd0);
      send_req(CMD_PUSH,   6'd13, 3'd1);
      send_req(CMD_PUSH,   6'd14, 3'd1);
      send_req(CMD_PUSH,   6'd15, 3'd1);
      send_req(CMD_REMOVE, 6'd14, 3'd7);
      send_req(CMD_REMOVE, 6'd13, 3'd0);
      send_req(CMD_REMOVE, 6'd15, 3'd0);
      send_req(CMD_NOP,    6'd63, 3'd7);
      send_req(CMD_PUSH,   6'd33, 3'd4);
      repeat (6) send_req(CMD_POP, 6'd0, 3'd0);
      send_req(CMD_POP,    6'd0,  3'd0);

      drain_responses();

      // random traffic in chunks of varying mix and idling
      for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
         mix    = traffic_mix_type'($urandom_range(0, 2));
         narrow = ($urandom_range(0, 3) == 0);
         if (chunk >= RANDOM_CHUNKS - QUIET_CHUNKS) begin
            sender_idle    = 1'b0;
            receiver_stall = 1'b0;
         end else begin
            sender_idle    = ($urandom_range(0, 2) != 0);
            receiver_stall = ($urandom_range(0, 2) != 0);
         end
         if (chunk == RANDOM_CHUNKS / 2) drain_responses();
         for (int n = 0; n < CHUNK_ITEMS; n++) random_req(mix, narrow);
      end

      drain_responses();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("multilevel_ready_queue_test: PASS");
      end else begin
         $display("multilevel_ready_queue_test: FAIL");
      end
      $finish;
   end

endmodule
